>>> design/nbfr_pkg.sv
// Shared types and constants of the nine-bit frame receiver.
package nbfr_pkg;

  localparam int FRAME_LEN = 5;
  localparam int COUNT_W   = $clog2(FRAME_LEN + 1);
  localparam int BYTE_W    = 8;
  localparam int CFG_IDX_W = 4;

  typedef logic [BYTE_W-1:0]    byte_t;
  typedef logic [COUNT_W-1:0]   count_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_NODE_ADDR  = CFG_IDX_W'(0);
  localparam cfg_idx_t REG_BCAST_ADDR = CFG_IDX_W'(1);

  localparam byte_t NODE_ADDR_RESET  = 8'h01;
  localparam byte_t BCAST_ADDR_RESET = 8'h00;

  typedef enum logic [2:0] {
    STATUS_NONE     = 3'd0,
    STATUS_ACCEPTED = 3'd1,
    STATUS_OTHER    = 3'd2,
    STATUS_BAD_SUM  = 3'd3,
    STATUS_ERR_DROP = 3'd4
  } status_t;

  typedef struct packed {
    status_t status;
    byte_t   frame_address;
    byte_t   payload_0;
    byte_t   payload_1;
    byte_t   payload_2;
    byte_t   payload_3;
  } result_t;

endpackage

>>> design/nbfr_if.sv
// Channel interfaces: received characters, frame results and register writes.
interface nbfr_rx_if import nbfr_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t rx_byte;
  logic  ninth_bit;
  logic  line_error;
  modport source (output valid, output rx_byte, output ninth_bit, output line_error,
                  input ready);
  modport sink (input valid, input rx_byte, input ninth_bit, input line_error,
                output ready);
endinterface

interface nbfr_res_if import nbfr_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] status;
  byte_t      frame_address;
  byte_t      payload_0;
  byte_t      payload_1;
  byte_t      payload_2;
  byte_t      payload_3;
  modport source (output valid, output status, output frame_address, output payload_0,
                  output payload_1, output payload_2, output payload_3, input ready);
  modport sink (input valid, input status, input frame_address, input payload_0,
                input payload_1, input payload_2, input payload_3, output ready);
endinterface

interface nbfr_cfg_if import nbfr_pkg::*; ();
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  byte_t    data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> design/nbfr_frame.sv
// Frame tracking: address registers, frame state and the per-character decision.
module nbfr_frame import nbfr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_fire,
  input  byte_t    ch,
  input  logic     nb,
  input  logic     err,
  input  logic     cfg_we,
  input  cfg_idx_t cfg_index,
  input  byte_t    cfg_data,
  output result_t  result
);

  byte_t  node_address;
  byte_t  broadcast_address;
  logic   in_frame, in_frame_next;
  count_t byte_count, byte_count_next;
  byte_t  running_sum, running_sum_next;
  byte_t  frame_bytes [FRAME_LEN];
  logic   byte_we;
  count_t byte_idx;

  always_comb begin
    result           = '0;
    result.status    = STATUS_NONE;
    in_frame_next    = in_frame;
    byte_count_next  = byte_count;
    running_sum_next = running_sum;
    byte_we          = 1'b0;
    byte_idx         = byte_count;
    if (err) begin
      if (in_frame) begin
        result.status = STATUS_ERR_DROP;
      end
      in_frame_next    = 1'b0;
      byte_count_next  = '0;
      running_sum_next = '0;
    end else if (nb) begin
      byte_we          = 1'b1;
      byte_idx         = '0;
      running_sum_next = ch;
      byte_count_next  = COUNT_W'(1);
      in_frame_next    = 1'b1;
    end else if (in_frame) begin
      if (byte_count < COUNT_W'(FRAME_LEN)) begin
        byte_we          = 1'b1;
        running_sum_next = running_sum + ch;
        byte_count_next  = byte_count + COUNT_W'(1);
      end else begin
        // Checksum character closes the frame whatever the outcome.
        if (running_sum != ch) begin
          result.status = STATUS_BAD_SUM;
        end else if (frame_bytes[0] == node_address ||
                     frame_bytes[0] == broadcast_address) begin
          result.status = STATUS_ACCEPTED;
        end else begin
          result.status = STATUS_OTHER;
        end
        result.frame_address = frame_bytes[0];
        result.payload_0     = frame_bytes[1];
        result.payload_1     = frame_bytes[2];
        result.payload_2     = frame_bytes[3];
        result.payload_3     = frame_bytes[4];
        in_frame_next        = 1'b0;
        byte_count_next      = '0;
        running_sum_next     = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame    <= 1'b0;
      byte_count  <= '0;
      running_sum <= '0;
    end else if (in_fire) begin
      in_frame    <= in_frame_next;
      byte_count  <= byte_count_next;
      running_sum <= running_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && byte_we) begin
      frame_bytes[byte_idx] <= ch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_address      <= NODE_ADDR_RESET;
      broadcast_address <= BCAST_ADDR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NODE_ADDR:  node_address      <= cfg_data;
        REG_BCAST_ADDR: broadcast_address <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

>>> design/nbfr_out_queue.sv
// Two-entry result register with skid slot between the frame logic and the result channel.
module nbfr_out_queue import nbfr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    can_push,
  output logic    head_valid,
  output result_t head_data,
  input  logic    pop
);

  logic    main_valid;
  logic    skid_valid;
  result_t main_data;
  result_t skid_data;

  assign can_push   = !skid_valid;
  assign head_valid = main_valid;
  assign head_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || pop) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= push;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid || pop) begin
      if (skid_valid) begin
        main_data <= skid_data;
        if (push) begin
          skid_data <= push_data;
        end
      end else if (push) begin
        main_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

>>> design/ninth_bit_frame_receiver_core.sv
// Top level of the nine-bit multidrop frame receiver.
//
// The receiver takes one 9-bit character per beat on rx (the low eight bits, the
// ninth bit and a line-error flag) and returns exactly one result beat on res for
// every character it takes. A character with the ninth bit set opens a frame as its
// address byte; four data bytes follow and then a checksum byte that must equal the
// 8-bit wrapping sum of the first five. On the checksum byte the result carries the
// frame and a status of accepted, other address or bad checksum; every other
// character gives status nothing, except a line error inside a frame, which gives
// error drop. The node and broadcast addresses are written on cfg (index 0 and 1,
// other indices are ignored); the user must write them only while the block is
// idle, which the block itself does not enforce. A character is decided in the
// cycle it is taken and its result is registered in the output queue before it
// appears on res; the block takes one character every cycle while the queue has
// room. A two-entry output queue lets a further character be taken while a
// finished result still waits, so rx.ready only falls once two results are held.
module ninth_bit_frame_receiver_core import nbfr_pkg::*; (
  input logic           clk,
  input logic           rst,
  nbfr_rx_if.sink       rx,
  nbfr_res_if.source    res,
  nbfr_cfg_if.sink      cfg
);

  logic    rx_fire;
  logic    can_push;
  result_t result;
  result_t head_data;

  assign rx.ready  = can_push;
  assign rx_fire   = rx.valid && rx.ready;
  assign cfg.ready = 1'b1;

  // Per-character decision and the frame state it advances.
  nbfr_frame u_frame (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (rx_fire),
    .ch        (rx.rx_byte),
    .nb        (rx.ninth_bit),
    .err       (rx.line_error),
    .cfg_we    (cfg.valid && cfg.ready),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .result    (result)
  );

  // Result register and skid slot towards the consumer.
  nbfr_out_queue u_out_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (rx_fire),
    .push_data  (result),
    .can_push   (can_push),
    .head_valid (res.valid),
    .head_data  (head_data),
    .pop        (res.valid && res.ready)
  );

  assign res.status        = 3'(head_data.status);
  assign res.frame_address = head_data.frame_address;
  assign res.payload_0     = head_data.payload_0;
  assign res.payload_1     = head_data.payload_1;
  assign res.payload_2     = head_data.payload_2;
  assign res.payload_3     = head_data.payload_3;

  // After every accepted character a result is held on res in the following cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    rx_fire |=> res.valid)
    else $error("no result after an accepted character");

  // Taking a character while the held result stalls fills the skid slot.
  a_skid_fills: assert property (@(posedge clk) disable iff (rst)
    (rx_fire && res.valid && !res.ready) |=> !rx.ready)
    else $error("skid slot not occupied after stalled accept");

  // Only the defined status codes appear on the result channel.
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.status <= 3'(STATUS_ERR_DROP)))
    else $error("undefined status code on result");

  // With nothing held the receiver is ready.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !res.valid |-> rx.ready)
    else $error("not ready while the result queue is empty");

endmodule
